@@ rtl/iso_dr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ISO 9660 directory record parser.
// No dependencies; every other file but the two channel interfaces imports this package.
package iso_dr_pkg;

    localparam int SECTOR_BYTES   = 2048;
    localparam int NAME_MAX_CHARS = 63;
    localparam int OFF_W          = $clog2(SECTOR_BYTES + 1);

    localparam logic [7:0] MIN_RECORD = 8'd33;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;

    // Result status codes.
    localparam logic [1:0] ST_ENTRY = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Work handed from the front to the back.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] rec_len;
    } job_t;

    // Record buffer write port driven by the front.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } buf_wr_t;

endpackage

@@ rtl/iso_dr_byte_if.sv @@
`timescale 1ns / 1ps
// Input channel: one directory extent byte per word.
// No dependencies.
interface iso_dr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

@@ rtl/iso_dr_entry_if.sv @@
`timescale 1ns / 1ps
// Output channel: one name character of a directory entry per word.
// No dependencies.
interface iso_dr_entry_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] entry_extent;
    logic [31:0] entry_size;
    logic [7:0]  entry_flags;
    logic [7:0]  name_char;
    logic [5:0]  name_length;
    logic        name_from_rock_ridge;
    logic        last_of_run;

    modport source (output valid, status, entry_extent, entry_size, entry_flags,
                    name_char, name_length, name_from_rock_ridge, last_of_run,
                    input ready);
    modport sink   (input valid, status, entry_extent, entry_size, entry_flags,
                    name_char, name_length, name_from_rock_ridge, last_of_run,
                    output ready);
endinterface

@@ rtl/iso_dr_front.sv @@
`timescale 1ns / 1ps
// Front end: tracks record framing, writes record bytes to the buffer
// and issues jobs. Depends on iso_dr_pkg.
module iso_dr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [7:0]         data_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    output iso_dr_pkg::buf_wr_t buf_wr,
    output logic               job_push,
    output iso_dr_pkg::job_t    job
);
    import iso_dr_pkg::*;

    localparam logic [1:0] MODE_AWAIT  = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    logic [1:0]     mode_reg, mode_next;
    logic [7:0]     rl_reg, rl_next;
    logic [7:0]     bir_reg, bir_next;
    logic [OFF_W-1:0] off_reg, off_next;

    logic [1:0]     m;
    logic [7:0]     rl;
    logic [7:0]     bir;
    logic [OFF_W-1:0] off;
    logic [OFF_W:0]   off_inc;

    // One step of the framing state per accepted word.
    always_comb
    begin
        m   = first_byte ? MODE_AWAIT : mode_reg;
        rl  = first_byte ? 8'd0 : rl_reg;
        bir = first_byte ? 8'd0 : bir_reg;
        off = first_byte ? '0 : off_reg;
        mode_next = m;
        rl_next   = rl;
        bir_next  = bir;
        off_next  = off;
        buf_wr    = '0;
        job_push  = 1'b0;
        job       = '0;
        off_inc   = {1'b0, off} + 1'b1;
        if (m != MODE_STOP)
        begin
            case (m)
                MODE_AWAIT:
                begin
                    if (data_byte == 8'd0)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else if (data_byte < MIN_RECORD)
                    begin
                        job_push   = 1'b1;
                        job.status = ST_SHORT;
                        mode_next  = MODE_STOP;
                    end
                    else
                    begin
                        rl_next     = data_byte;
                        buf_wr.en   = 1'b1;
                        buf_wr.addr = 8'd0;
                        buf_wr.data = data_byte;
                        bir_next    = 8'd1;
                        mode_next   = MODE_RECORD;
                    end
                end
                MODE_RECORD:
                begin
                    buf_wr.en   = 1'b1;
                    buf_wr.addr = bir;
                    buf_wr.data = data_byte;
                    bir_next    = bir + 8'd1;
                    if (bir_next == rl)
                    begin
                        job_push    = 1'b1;
                        job.status  = ST_ENTRY;
                        job.rec_len = rl;
                        mode_next   = MODE_AWAIT;
                    end
                end
                default:
                begin
                    mode_next = m;
                end
            endcase
            if (off_inc >= (OFF_W+1)'(SECTOR_BYTES))
                off_next = '0;
            else
                off_next = off_inc[OFF_W-1:0];
            if (mode_next == MODE_SKIP && off_next == '0)
                mode_next = MODE_AWAIT;
            if (last_byte)
            begin
                if (mode_next == MODE_RECORD)
                begin
                    job_push   = 1'b1;
                    job.status = ST_TRUNC;
                    job.rec_len = 8'd0;
                end
                mode_next = MODE_STOP;
            end
        end
        if (!in_fire)
        begin
            buf_wr.en = 1'b0;
            job_push  = 1'b0;
        end
    end

    // Framing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_AWAIT;
            rl_reg   <= '0;
            bir_reg  <= '0;
            off_reg  <= '0;
        end
        else if (in_fire)
        begin
            mode_reg <= mode_next;
            rl_reg   <= rl_next;
            bir_reg  <= bir_next;
            off_reg  <= off_next;
        end
    end
endmodule

@@ rtl/iso_dr_queue.sv @@
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// Depends on iso_dr_pkg.
module iso_dr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  iso_dr_pkg::job_t push_job,
    input  logic             pop,
    output iso_dr_pkg::job_t head,
    output logic             empty,
    output logic             full
);
    import iso_dr_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rp_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wp_reg] <= push_job;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end
endmodule

@@ rtl/iso_dr_back.sv @@
`timescale 1ns / 1ps
// Back end: holds the record buffer, resolves the name and emits one
// word per name character. Depends on iso_dr_pkg.
module iso_dr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  iso_dr_pkg::buf_wr_t buf_wr,
    input  logic                job_valid,
    input  iso_dr_pkg::job_t    job,
    output logic                job_pop,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [31:0]         entry_extent,
    output logic [31:0]         entry_size,
    output logic [7:0]          entry_flags,
    output logic [7:0]          name_char,
    output logic [5:0]          name_length,
    output logic                name_from_rock_ridge,
    output logic                last_of_run
);
    import iso_dr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ERR    = 3'd1;
    localparam logic [2:0] S_FIELDS = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SUA    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam logic [1:0] K_ISO    = 2'd0;
    localparam logic [1:0] K_DOT    = 2'd1;
    localparam logic [1:0] K_DOTDOT = 2'd2;
    localparam logic [1:0] K_RR     = 2'd3;

    logic [7:0] mem [256];
    logic [7:0] rdata;
    logic [7:0] rd_addr;

    logic [2:0]  state_reg;
    logic        pend_reg;
    logic [7:0]  cnt_reg;
    logic [1:0]  err_reg;
    logic [31:0] ext_reg, size_reg;
    logic [7:0]  flags_reg, idlen_reg, rl_reg, rawlen_reg, pos_reg;
    logic [5:0]  lastnd_reg, nlen_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  h0_reg, h1_reg, h2_reg, start_reg;

    logic        out_free;
    logic        emit_fire;
    logic [9:0]  sua_off, base;
    logic [7:0]  sua_len, rl_room, elen;
    logic [8:0]  pos_end;
    logic [5:0]  out_len;
    logic [7:0]  name_start, ch;
    logic [7:0]  cap_nlen;

    assign out_free  = !out_valid || out_ready;
    assign busy      = (state_reg != S_IDLE);
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign emit_fire = out_free && ((state_reg == S_ERR) || (state_reg == S_EMIT && pend_reg));

    // System use area bounds and the resolved name.
    always_comb
    begin
        sua_off = 10'd33 + {2'd0, idlen_reg} + {9'd0, ~idlen_reg[0]};
        sua_len = (sua_off < {2'd0, rl_reg}) ? 8'({2'd0, rl_reg} - sua_off) : 8'd0;
        rl_room = rl_reg - MIN_RECORD;
        base    = sua_off + {2'd0, pos_reg};
        elen    = h2_reg;
        pos_end = {1'b0, pos_reg} + {1'b0, elen};
        cap_nlen = (elen - 8'd5 > 8'(NAME_MAX_CHARS)) ? 8'(NAME_MAX_CHARS) : elen - 8'd5;
        case (kind_reg)
            K_DOT:    out_len = 6'd1;
            K_DOTDOT: out_len = 6'd2;
            K_RR:     out_len = nlen_reg;
            default:  out_len = lastnd_reg;
        endcase
        name_start = (kind_reg == K_RR) ? start_reg : MIN_RECORD;
        case (kind_reg)
            K_DOT, K_DOTDOT: ch = CHAR_DOT;
            K_RR:            ch = rdata;
            default:
            begin
                if (rdata >= CHAR_UA && rdata <= CHAR_UZ)
                    ch = rdata + 8'h20;
                else
                    ch = rdata;
            end
        endcase
        if (out_len == 6'd0)
            ch = 8'd0;
    end

    // Read address for the current step.
    always_comb
    begin
        case (state_reg)
            S_FIELDS:
            begin
                if (cnt_reg < 8'd4)
                    rd_addr = 8'd2 + cnt_reg;
                else if (cnt_reg < 8'd8)
                    rd_addr = 8'd6 + cnt_reg;
                else if (cnt_reg == 8'd8)
                    rd_addr = 8'd25;
                else
                    rd_addr = 8'd32;
            end
            S_SCAN:  rd_addr = MIN_RECORD + cnt_reg;
            S_SUA:   rd_addr = base[7:0] + {6'd0, cnt_reg[1:0]};
            S_EMIT:  rd_addr = name_start + cnt_reg;
            default: rd_addr = 8'd0;
        endcase
    end

    // Record buffer.
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            mem[buf_wr.addr] <= buf_wr.data;
        rdata <= mem[rd_addr];
    end

    // Output word valid flag: set by a new word, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (emit_fire)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    cnt_reg  <= '0;
                    if (job_valid)
                    begin
                        rl_reg  <= job.rec_len;
                        err_reg <= job.status;
                        if (job.status == ST_ENTRY)
                            state_reg <= S_FIELDS;
                        else
                            state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        status               <= err_reg;
                        entry_extent         <= '0;
                        entry_size           <= '0;
                        entry_flags          <= '0;
                        name_char            <= '0;
                        name_length          <= '0;
                        name_from_rock_ridge <= 1'b0;
                        last_of_run          <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                S_FIELDS:
                begin
                    pend_reg <= ~pend_reg;
                    if (pend_reg)
                    begin
                        cnt_reg <= cnt_reg + 8'd1;
                        if (cnt_reg < 8'd4)
                            ext_reg <= {rdata, ext_reg[31:8]};
                        else if (cnt_reg < 8'd8)
                            size_reg <= {rdata, size_reg[31:8]};
                        else if (cnt_reg == 8'd8)
                            flags_reg <= rdata;
                        else
                        begin
                            idlen_reg  <= rdata;
                            rawlen_reg <= (rdata > rl_room) ? rl_room : rdata;
                            lastnd_reg <= '0;
                            kind_reg   <= K_ISO;
                            cnt_reg    <= '0;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (!pend_reg)
                    begin
                        if (cnt_reg == rawlen_reg || cnt_reg == 8'(NAME_MAX_CHARS))
                        begin
                            cnt_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_SUA;
                        end
                        else
                            pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (cnt_reg == 8'd0 && rawlen_reg == 8'd1 && rdata == 8'd0)
                        begin
                            kind_reg  <= K_DOT;
                            cnt_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_SUA;
                        end
                        else if (cnt_reg == 8'd0 && rawlen_reg == 8'd1 && rdata == 8'd1)
                        begin
                            kind_reg  <= K_DOTDOT;
                            cnt_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_SUA;
                        end
                        else if (rdata == CHAR_SEMI)
                        begin
                            cnt_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_SUA;
                        end
                        else
                        begin
                            if (rdata != CHAR_DOT)
                                lastnd_reg <= 6'(cnt_reg + 8'd1);
                            cnt_reg <= cnt_reg + 8'd1;
                        end
                    end
                end
                S_SUA:
                begin
                    if (!pend_reg)
                    begin
                        if ({1'b0, pos_reg} + 9'd4 > {1'b0, sua_len})
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                            pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        case (cnt_reg[1:0])
                            2'd0:
                            begin
                                h0_reg  <= rdata;
                                cnt_reg <= cnt_reg + 8'd1;
                            end
                            2'd1:
                            begin
                                h1_reg  <= rdata;
                                cnt_reg <= cnt_reg + 8'd1;
                            end
                            2'd2:
                            begin
                                h2_reg  <= rdata;
                                cnt_reg <= cnt_reg + 8'd1;
                            end
                            default:
                            begin
                                cnt_reg <= '0;
                                if (elen < 8'd4 || pos_end > {1'b0, sua_len})
                                    state_reg <= S_EMIT;
                                else if (h0_reg == CHAR_N && h1_reg == CHAR_M
                                         && rdata == 8'd1 && elen > 8'd5)
                                begin
                                    kind_reg  <= K_RR;
                                    start_reg <= base[7:0] + 8'd5;
                                    nlen_reg  <= cap_nlen[5:0];
                                    state_reg <= S_EMIT;
                                end
                                else
                                    pos_reg <= pos_end[7:0];
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (!pend_reg)
                        pend_reg <= 1'b1;
                    else if (out_free)
                    begin
                        pend_reg             <= 1'b0;
                        status               <= ST_ENTRY;
                        entry_extent         <= ext_reg;
                        entry_size           <= size_reg;
                        entry_flags          <= flags_reg;
                        name_char            <= ch;
                        name_length          <= out_len;
                        name_from_rock_ridge <= (kind_reg == K_RR);
                        if (out_len == 6'd0 || cnt_reg[5:0] == out_len - 6'd1)
                        begin
                            last_of_run <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            last_of_run <= 1'b0;
                            cnt_reg     <= cnt_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ rtl/iso9660_dir_record_parser_core.sv @@
`timescale 1ns / 1ps
// ISO 9660 directory record parser, top level.
// Depends on iso_dr_pkg, the two channel interfaces, front, queue and back.
//
// Usage: dir_bytes carries one byte of a directory extent per word, with
// first_byte marking the start of a new directory (the parser restarts
// before that byte) and last_byte marking the final byte of the extent.
// entries carries the results: one word per character of a resolved name,
// last_of_run set on the final word of a record, or a single error word.
// Bytes are taken one per cycle while a record is gathered. Once a record
// completes, the back end reads the record buffer one byte at a time:
// ten field bytes, the identifier (up to 63 bytes), four bytes per system
// use entry, then one word out per name character.
// The input stalls while a record is queued or being resolved, since the
// back end reads the same buffer that the front end fills.
// Reset clears all control state; the buffer needs no clearing. When the
// receiver stalls, the output word holds and the back end waits.
module iso9660_dir_record_parser_core (
    input  logic           clk,
    input  logic           rst_n,
    iso_dr_byte_if.sink    dir_bytes,
    iso_dr_entry_if.source entries
);
    import iso_dr_pkg::*;

    buf_wr_t buf_wr;
    job_t    push_job, head;
    logic    job_push, empty, full, job_pop, back_busy, in_fire;

    // Hold input while a record is waiting or being resolved.
    assign dir_bytes.ready = !back_busy && empty && !full;
    assign in_fire         = dir_bytes.valid && dir_bytes.ready;

    iso_dr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (dir_bytes.data_byte),
        .first_byte (dir_bytes.first_byte),
        .last_byte  (dir_bytes.last_byte),
        .buf_wr     (buf_wr),
        .job_push   (job_push),
        .job        (push_job)
    );

    iso_dr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    iso_dr_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .buf_wr               (buf_wr),
        .job_valid            (!empty),
        .job                  (head),
        .job_pop              (job_pop),
        .busy                 (back_busy),
        .out_valid            (entries.valid),
        .out_ready            (entries.ready),
        .status               (entries.status),
        .entry_extent         (entries.entry_extent),
        .entry_size           (entries.entry_size),
        .entry_flags          (entries.entry_flags),
        .name_char            (entries.name_char),
        .name_length          (entries.name_length),
        .name_from_rock_ridge (entries.name_from_rock_ridge),
        .last_of_run          (entries.last_of_run)
    );
endmodule

@@ tb/iso_dr_tb_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the directory record parser testbench: it predicts the
// entry words from accepted extent bytes and checks received words.
// Depends on iso_dr_pkg.
package iso_dr_tb_pkg;
    import iso_dr_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] extent;
        logic [31:0] size;
        logic [7:0]  flags;
        logic [7:0]  ch;
        logic [5:0]  char_count;
        logic        rr;
        logic        last;
    } entry_word_t;

    typedef enum logic [1:0] {PM_AWAIT, PM_RECORD, PM_SKIP, PM_STOP} parse_mode_e;

    class dir_scoreboard;
        logic [7:0]   rec_bytes [256];
        logic [7:0]   rec_len;
        logic [7:0]   rec_pos;
        int           sector_pos;
        parse_mode_e  mode;
        entry_word_t  pending [$];
        int           errors;

        function new();
            rec_len = 0;
            rec_pos = 0;
            sector_pos = 0;
            mode = PM_AWAIT;
            errors = 0;
        endfunction

        function logic [31:0] le32(int at);
            return {rec_bytes[(at + 3) & 255], rec_bytes[(at + 2) & 255],
                    rec_bytes[(at + 1) & 255], rec_bytes[at & 255]};
        endfunction

        function void push_error(logic [1:0] st);
            entry_word_t w;
            w = '0;
            w.status = st;
            w.last = 1'b1;
            pending.push_back(w);
        endfunction

        // Resolve the name of a complete record and queue its words.
        function void emit_record();
            logic [7:0] name [64];
            int rl, id_len, raw, nlen, stop, sua_off, sua_len, pos, base, elen, cnt;
            logic rr;
            entry_word_t w;
            rl = rec_len;
            id_len = rec_bytes[32];
            raw = id_len;
            nlen = 0;
            rr = 0;
            if (raw > rl - MIN_RECORD) raw = rl - MIN_RECORD;
            if (raw == 1 && rec_bytes[MIN_RECORD] == 8'd0) begin
                name[0] = CHAR_DOT;
                nlen = 1;
            end
            else if (raw == 1 && rec_bytes[MIN_RECORD] == 8'd1) begin
                name[0] = CHAR_DOT;
                name[1] = CHAR_DOT;
                nlen = 2;
            end
            else begin
                stop = raw;
                for (int i = 0; i < raw; i++)
                    if (rec_bytes[(MIN_RECORD + i) & 255] == CHAR_SEMI) begin
                        stop = i;
                        break;
                    end
                for (int i = 0; i < stop && nlen < NAME_MAX_CHARS; i++)
                    name[nlen++] = rec_bytes[(MIN_RECORD + i) & 255];
                while (nlen > 0 && name[nlen - 1] == CHAR_DOT) nlen--;
                for (int i = 0; i < nlen; i++)
                    if (name[i] >= CHAR_UA && name[i] <= CHAR_UZ)
                        name[i] = name[i] + 8'd32;
            end
            // Walk the system use area looking for an NM entry.
            sua_off = MIN_RECORD + id_len + ((id_len % 2) == 0 ? 1 : 0);
            sua_len = sua_off < rl ? rl - sua_off : 0;
            pos = 0;
            while (pos + 4 <= sua_len) begin
                base = sua_off + pos;
                elen = rec_bytes[(base + 2) & 255];
                if (elen < 4 || pos + elen > sua_len) break;
                if (rec_bytes[base & 255] == CHAR_N && rec_bytes[(base + 1) & 255] == CHAR_M
                    && rec_bytes[(base + 3) & 255] == 8'd1 && elen > 5) begin
                    nlen = elen - 5;
                    if (nlen > NAME_MAX_CHARS) nlen = NAME_MAX_CHARS;
                    for (int i = 0; i < nlen; i++)
                        name[i] = rec_bytes[(base + 5 + i) & 255];
                    rr = 1;
                    break;
                end
                pos += elen;
            end
            cnt = nlen ? nlen : 1;
            for (int k = 0; k < cnt; k++) begin
                w.status = ST_ENTRY;
                w.extent = le32(2);
                w.size = le32(10);
                w.flags = rec_bytes[25];
                w.ch = nlen ? name[k] : 8'd0;
                w.char_count = nlen[5:0];
                w.rr = rr;
                w.last = (k == cnt - 1);
                pending.push_back(w);
            end
        endfunction

        // Note one accepted extent byte.
        function void note_byte(logic [7:0] d, logic first, logic last);
            if (first) begin
                mode = PM_AWAIT;
                sector_pos = 0;
                rec_pos = 0;
                rec_len = 0;
            end
            if (mode == PM_STOP) return;
            if (mode == PM_AWAIT) begin
                if (d == 0) mode = PM_SKIP;
                else if (d < MIN_RECORD) begin
                    push_error(ST_SHORT);
                    mode = PM_STOP;
                end
                else begin
                    rec_len = d;
                    rec_bytes[0] = d;
                    rec_pos = 1;
                    mode = PM_RECORD;
                end
            end
            else if (mode == PM_RECORD) begin
                rec_bytes[rec_pos] = d;
                rec_pos = rec_pos + 8'd1;
                if (rec_pos == rec_len) begin
                    emit_record();
                    mode = PM_AWAIT;
                end
            end
            sector_pos = sector_pos + 1;
            if (sector_pos >= SECTOR_BYTES) sector_pos = 0;
            if (mode == PM_SKIP && sector_pos == 0) mode = PM_AWAIT;
            if (last) begin
                if (mode == PM_RECORD) push_error(ST_TRUNC);
                mode = PM_STOP;
            end
        endfunction

        // Compare one received word with the oldest expectation.
        function void check_word(entry_word_t got);
            entry_word_t exp_w;
            if (pending.size() == 0) begin
                $error("unexpected entry word %h", got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.status !== exp_w.status) begin
                $error("status exp %0d got %0d", exp_w.status, got.status); errors++;
            end
            if (got.extent !== exp_w.extent) begin
                $error("entry_extent exp %h got %h", exp_w.extent, got.extent); errors++;
            end
            if (got.size !== exp_w.size) begin
                $error("entry_size exp %h got %h", exp_w.size, got.size); errors++;
            end
            if (got.flags !== exp_w.flags) begin
                $error("entry_flags exp %h got %h", exp_w.flags, got.flags); errors++;
            end
            if (got.ch !== exp_w.ch) begin
                $error("name_char exp %h got %h", exp_w.ch, got.ch); errors++;
            end
            if (got.char_count !== exp_w.char_count) begin
                $error("name_length exp %0d got %0d", exp_w.char_count, got.char_count);
                errors++;
            end
            if (got.rr !== exp_w.rr) begin
                $error("name_from_rock_ridge exp %b got %b", exp_w.rr, got.rr); errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last_of_run exp %b got %b", exp_w.last, got.last); errors++;
            end
        endfunction
    endclass
endpackage

@@ tb/iso9660_dir_record_parser_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the directory record parser testbench: builds extent byte streams,
// drives them with random idling and checks entries via the scoreboard.
// Depends on iso_dr_pkg, the channel interfaces, iso_dr_tb_pkg and the core.
module iso9660_dir_record_parser_core_tb;
    import iso_dr_pkg::*;
    import iso_dr_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 420;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    int   bytes_sent;

    logic [7:0] stream_data [$];
    logic       stream_first [$];
    logic       stream_last [$];

    iso_dr_byte_if  dir_bytes ();
    iso_dr_entry_if entries ();

    dir_scoreboard board;

    iso9660_dir_record_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir_bytes (dir_bytes.sink),
        .entries   (entries.source)
    );

    always #6 clk = ~clk;

    // Receiver side: random stall and checking on every accepted word.
    always @(posedge clk) begin
        entry_word_t w;
        if (rst_n && entries.valid && entries.ready) begin
            w.status = entries.status;
            w.extent = entries.entry_extent;
            w.size = entries.entry_size;
            w.flags = entries.entry_flags;
            w.ch = entries.name_char;
            w.char_count = entries.name_length;
            w.rr = entries.name_from_rock_ridge;
            w.last = entries.last_of_run;
            board.check_word(w);
        end
        entries.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no word accepted on either side.
    always @(posedge clk) begin
        if ((dir_bytes.valid && dir_bytes.ready) || (entries.valid && entries.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] d, logic first = 0, logic last = 0);
        stream_data.push_back(d);
        stream_first.push_back(first);
        stream_last.push_back(last);
    endtask

    // Queue one record; name and system use content chosen by the arguments and at random.
    task automatic add_record(int id_len, int nm_len, bit semi, bit first);
        logic [7:0] rec [$];
        int sua_off;
        int len;
        rec = {};
        for (int i = 0; i < 33; i++) rec.push_back(8'($urandom_range(255)));
        rec[32] = 8'(id_len);
        for (int i = 0; i < id_len; i++) begin
            case ($urandom_range(5))
                0: rec.push_back(CHAR_DOT);
                1: rec.push_back(semi ? CHAR_SEMI : 8'(8'h41 + $urandom_range(25)));
                2: rec.push_back(8'(8'h41 + $urandom_range(25)));
                3: rec.push_back(8'(8'h61 + $urandom_range(25)));
                default: rec.push_back(8'($urandom_range(255)));
            endcase
        end
        if ((id_len % 2) == 0) rec.push_back(8'($urandom_range(255)));
        sua_off = rec.size();
        if ($urandom_range(3) == 0) begin
            // An unrelated entry ahead of the name entry.
            rec.push_back(8'h50);
            rec.push_back(8'h58);
            rec.push_back(8'(8'd4 + $urandom_range(4)));
            rec.push_back(8'd1);
            for (int i = 4; i < rec[sua_off + 2]; i++) rec.push_back(8'($urandom_range(255)));
        end
        if (nm_len >= 0) begin
            rec.push_back(CHAR_N);
            rec.push_back(CHAR_M);
            rec.push_back(8'(nm_len + 5));
            rec.push_back($urandom_range(7) == 0 ? 8'd2 : 8'd1);
            rec.push_back(8'd0);
            for (int i = 0; i < nm_len; i++) rec.push_back(8'($urandom_range(255)));
        end
        if (rec.size() > 255) rec = rec[0:254];
        len = rec.size();
        if ($urandom_range(5) == 0 && len < 255) len = len + $urandom_range(255 - len);
        while (rec.size() < len) rec.push_back(8'($urandom_range(255)));
        // Occasionally clip the record so the identifier may be cut short.
        if ($urandom_range(7) == 0) len = 33 + $urandom_range(id_len < 200 ? id_len : 200);
        rec[0] = 8'(len);
        for (int i = 0; i < len; i++) add_byte(rec[i], first && i == 0);
    endtask

    // Queue a whole directory: one or two records then optional tail handling.
    task automatic add_directory();
        int nrec;
        int kind;
        nrec = 1 + $urandom_range(1);
        for (int r = 0; r < nrec; r++)
            add_record($urandom_range(3) == 0 ? $urandom_range(1, 2) : $urandom_range(20),
                       $urandom_range(2) == 0 ? $urandom_range(70) : -1,
                       $urandom_range(1), r == 0);
        kind = $urandom_range(9);
        if (kind == 0) add_byte(8'($urandom_range(1, 32)));
        else if (kind == 1) begin
            add_byte(8'd40);
            repeat (5) add_byte(8'($urandom_range(255)));
        end
        else if (kind == 2) add_byte(8'($urandom_range(255)));
        stream_last[stream_last.size() - 1] = 1'b1;
        if ($urandom_range(3) == 0)
            repeat (3) add_byte(8'($urandom_range(255)), 0, 1'($urandom_range(1)));
    endtask

    task automatic send_stream();
        while (stream_data.size() > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                dir_bytes.valid <= 1'b0;
                @(posedge clk);
            end
            dir_bytes.valid <= 1'b1;
            dir_bytes.data_byte <= stream_data.pop_front();
            dir_bytes.first_byte <= stream_first.pop_front();
            dir_bytes.last_byte <= stream_last.pop_front();
            @(posedge clk);
            while (!dir_bytes.ready) @(posedge clk);
            board.note_byte(dir_bytes.data_byte, dir_bytes.first_byte, dir_bytes.last_byte);
            bytes_sent++;
        end
        dir_bytes.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial begin
        board = new();
        quiet_cycles = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        dir_bytes.valid = 1'b0;
        dir_bytes.data_byte = 8'd0;
        dir_bytes.first_byte = 1'b0;
        dir_bytes.last_byte = 1'b0;
        entries.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dot, a long identifier, empty name, skip mode, a new
        // directory in mid stream, truncation and a record ending on the
        // last byte.
        add_record(1, -1, 0, 1);
        stream_data[stream_data.size() - (stream_data.size() - 33)] = 8'd0;
        add_record(64, -1, 0, 0);
        add_record(0, -1, 0, 0);
        add_byte(8'd0);
        repeat (6) add_byte(8'hFF);
        add_byte(8'd32, 0, 0);
        add_byte(8'd255, 1, 0);
        repeat (6) add_byte(8'hFF);
        stream_last[stream_last.size() - 1] = 1'b1;
        add_record(4, -1, 0, 1);
        stream_last[stream_last.size() - 1] = 1'b1;
        add_byte(8'd1, 1, 1);
        send_stream();

        // Random directories over three idling profiles.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 12 : 0;
            do begin
                add_directory();
                send_stream();
            end while (bytes_sent < (ITEM_TARGET * (phase + 1)) / 3);
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ iso9660_dir_record_parser_core.f @@
rtl/iso_dr_pkg.sv
rtl/iso_dr_byte_if.sv
rtl/iso_dr_entry_if.sv
rtl/iso_dr_front.sv
rtl/iso_dr_queue.sv
rtl/iso_dr_back.sv
rtl/iso9660_dir_record_parser_core.sv
tb/iso_dr_tb_scoreboard.sv
tb/iso9660_dir_record_parser_core_tb.sv
